/* rtl/stc_pkg.sv */
// Shared types and constants for the scanline triangle filler.
package stc_pkg;

  localparam int CW             = 9;
  localparam int COLW           = 8;
  localparam int NW             = CW + 1;
  localparam int RW             = CW + 1;
  localparam int DEF_SCREEN_W   = 512;
  localparam int DEF_SCREEN_H   = 512;
  localparam int DEF_FRAC_BITS  = 16;
  localparam logic [COLW-1:0] ALPHA = 8'hFF;
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_TICK = 1'b1;

  typedef enum logic [1:0] {PH_IDLE, PH_TOP, PH_BOT, PH_EDGE} phase_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_DIV, OP_WB, OP_EDGE, OP_DDA, OP_RUN, OP_TICK
  } op_e;

  typedef enum logic [2:0] {SEL_SPLIT, SEL_AX, SEL_AY, SEL_BX, SEL_SX, SEL_SY} sel_e;

  typedef struct packed {
    op_e           op;
    sel_e          sel;
    phase_e        phase;
    logic [RW-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic flat;
    logic n_zero;
    logic rem_one;
    logic row_end;
    logic div_busy;
  } sts_t;

endpackage

/* rtl/scanline_triangle_filler_unit.sv */
// Top level of the scanline triangle filler: controller plus datapath.
//
// Input channel (in_valid_i / in_stall_o) takes requests: opcode 0 loads three
// vertices and a colour, opcode 1 is a tick that asks for the next pixel.
// Output channel (out_valid_o / out_stall_i) returns one pixel per tick while
// a triangle is being drawn; last_pixel_o marks the final pixel. A tick while
// idle returns nothing; a load returns nothing and abandons any triangle.
// A tick inside a span, other than the span's last, has its pixel valid the next cycle.
// Every new span or edge is set up by the sequencer around one shared
// multiplier and a one-bit-per-cycle divider of 2*9+FRAC_BITS bits: five
// divisions per fill span (three for a zero-length one) and two per edge
// (none for a zero-length edge). A load of a triangle that is not flat
// costs one more division for the split point. in_stall_o is high during
// setup. The output register holds a pixel until taken; a new request
// is taken in the same cycle the held pixel leaves. Reset returns to idle
// with no pixel pending.
module scanline_triangle_filler_unit #(
  parameter int SCREEN_WIDTH  = stc_pkg::DEF_SCREEN_W,
  parameter int SCREEN_HEIGHT = stc_pkg::DEF_SCREEN_H,
  parameter int FRAC_BITS     = stc_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [stc_pkg::CW-1:0]     vert_a_x_i,
  input  logic [stc_pkg::CW-1:0]     vert_a_y_i,
  input  logic [stc_pkg::CW-1:0]     vert_b_x_i,
  input  logic [stc_pkg::CW-1:0]     vert_b_y_i,
  input  logic [stc_pkg::CW-1:0]     vert_c_x_i,
  input  logic [stc_pkg::CW-1:0]     vert_c_y_i,
  input  logic [stc_pkg::COLW-1:0]   red_i,
  input  logic [stc_pkg::COLW-1:0]   green_i,
  input  logic [stc_pkg::COLW-1:0]   blue_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [stc_pkg::CW-1:0]     pixel_x_o,
  output logic [stc_pkg::CW-1:0]     pixel_y_o,
  output logic [4*stc_pkg::COLW-1:0] pixel_word_o,
  output logic                       last_pixel_o
);
  import stc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .opcode_i     (opcode_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .last_pixel_o (last_pixel_o),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  stc_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .vert_a_x_i   (vert_a_x_i),
    .vert_a_y_i   (vert_a_y_i),
    .vert_b_x_i   (vert_b_x_i),
    .vert_b_y_i   (vert_b_y_i),
    .vert_c_x_i   (vert_c_x_i),
    .vert_c_y_i   (vert_c_y_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_word_o (pixel_word_o)
  );
endmodule

/* rtl/stc_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module stc_div #(
  parameter int DVW = 34,
  parameter int DSW = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           busy_o,
  output logic [DVW-1:0] quot_o
);
  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [DVW-1:0]  quo_q;
  logic [DSW:0]    rem_q;
  logic [DSW-1:0]  div_q;
  logic [DSW:0]    shl;
  logic [DSW+1:0]  trial;

  assign shl   = {rem_q[DSW-1:0], quo_q[DVW-1]};
  assign trial = {1'b0, shl} - {2'b00, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(DVW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[DSW+1]) begin
        rem_q <= trial[DSW:0];
        quo_q <= {quo_q[DVW-2:0], 1'b1};
      end else begin
        rem_q <= shl;
        quo_q <= {quo_q[DVW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
endmodule

/* rtl/stc_datapath.sv */
// Datapath: vertex store, span setup arithmetic, DDA stepping and pixel output registers.
module stc_datapath #(
  parameter int SCREEN_WIDTH  = stc_pkg::DEF_SCREEN_W,
  parameter int SCREEN_HEIGHT = stc_pkg::DEF_SCREEN_H,
  parameter int FRAC_BITS     = stc_pkg::DEF_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stc_pkg::cmd_t             cmd_i,
  output stc_pkg::sts_t             sts_o,
  input  logic [stc_pkg::CW-1:0]    vert_a_x_i,
  input  logic [stc_pkg::CW-1:0]    vert_a_y_i,
  input  logic [stc_pkg::CW-1:0]    vert_b_x_i,
  input  logic [stc_pkg::CW-1:0]    vert_b_y_i,
  input  logic [stc_pkg::CW-1:0]    vert_c_x_i,
  input  logic [stc_pkg::CW-1:0]    vert_c_y_i,
  input  logic [stc_pkg::COLW-1:0]  red_i,
  input  logic [stc_pkg::COLW-1:0]  green_i,
  input  logic [stc_pkg::COLW-1:0]  blue_i,
  output logic [stc_pkg::CW-1:0]    pixel_x_o,
  output logic [stc_pkg::CW-1:0]    pixel_y_o,
  output logic [4*stc_pkg::COLW-1:0] pixel_word_o
);
  import stc_pkg::*;

  localparam int PW  = CW + FRAC_BITS + 2;
  localparam int DVW = 2 * CW + FRAC_BITS;

  logic [CW-1:0] s0_q, s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [CW-1:0] oax_q, oay_q, obx_q, oby_q, ocx_q, ocy_q;
  logic [3*COLW-1:0] colour_q;
  logic signed [PW-1:0] split_q, ax_q, ay_q, bx_q, by_q, dx_q, dy_q, stx_q, sty_q;
  logic [NW-1:0] n_q, den_q;
  logic [NW-1:0] rem_q;
  logic signed [DVW:0] prod_q;
  logic [CW-1:0] px_q, py_q;
  logic [4*COLW-1:0] word_q;

  // sort network
  logic [CW-1:0] t0x, t0y, t1x, t1y, t2x, t2y;
  logic [CW-1:0] tmpx, tmpy;
  always_comb begin
    tmpx = '0; tmpy = '0;
    t0x = vert_a_x_i; t0y = vert_a_y_i;
    t1x = vert_b_x_i; t1y = vert_b_y_i;
    t2x = vert_c_x_i; t2y = vert_c_y_i;
    if (t0y < t1y) begin
      tmpx = t0x; tmpy = t0y; t0x = t1x; t0y = t1y; t1x = tmpx; t1y = tmpy;
    end
    if (t0y < t2y) begin
      tmpx = t0x; tmpy = t0y; t0x = t2x; t0y = t2y; t2x = tmpx; t2y = tmpy;
    end
    if (t1y < t2y) begin
      tmpx = t1x; tmpy = t1y; t1x = t2x; t1y = t2y; t2x = tmpx; t2y = tmpy;
    end
  end

  function automatic logic signed [PW-1:0] scl(input logic [CW-1:0] v);
    logic signed [PW-1:0] e;
    e = $signed({{(PW-CW){1'b0}}, v});
    return e <<< FRAC_BITS;
  endfunction

  function automatic logic [CW-1:0] to_pix(input logic signed [PW-1:0] v, input int lim);
    int p;
    p = v[PW-1] ? 0 : int'(v[PW-1:FRAC_BITS]);
    if (p > lim - 1) p = lim - 1;
    return p[CW-1:0];
  endfunction

  // span bases
  logic [CW-1:0] bx0, by0;
  logic [NW-1:0] span_den;
  always_comb begin
    if (cmd_i.phase == PH_BOT) begin
      bx0 = s4_q; by0 = s5_q;
      span_den = {1'b0, s3_q} - {1'b0, s5_q} + NW'(1);
    end else begin
      bx0 = s0_q; by0 = s1_q;
      span_den = {1'b0, s1_q} - {1'b0, s3_q} + NW'(1);
    end
  end

  // multiplier operand select
  logic signed [NW:0] mul_a;
  logic signed [PW-1:0] mul_b;
  logic signed [PW-1:0] mul_d;
  logic [NW-1:0] den_d;
  logic signed [NW:0] row_s;
  logic signed [NW+PW:0] prod_w;
  assign row_s = $signed({1'b0, cmd_i.row});
  always_comb begin
    mul_a = row_s;
    mul_d = '0;
    den_d = span_den;
    case (cmd_i.sel)
      SEL_SPLIT: begin
        mul_a = $signed({1'b0, {1'b0, s1_q} - {1'b0, s3_q}});
        mul_d = scl(s0_q) - scl(s4_q);
        den_d = {1'b0, s1_q} - {1'b0, s5_q};
      end
      SEL_AX: mul_d = split_q - scl(bx0);
      SEL_AY: mul_d = scl(s3_q) - scl(by0);
      SEL_BX: mul_d = scl(s2_q) - scl(bx0);
      SEL_SX: begin
        mul_a = (NW+1)'(1);
        mul_d = dx_q;
        den_d = n_q;
      end
      SEL_SY: begin
        mul_a = (NW+1)'(1);
        mul_d = dy_q;
        den_d = n_q;
      end
      default: mul_d = '0;
    endcase
    mul_b = mul_d;
  end
  assign prod_w = mul_a * mul_b;

  // divider
  logic           prod_neg;
  logic [DVW-1:0] prod_mag, quot_mag;
  logic [DVW:0]   prod_abs;
  logic           div_busy;
  logic signed [PW-1:0] quot_s;
  assign prod_neg = prod_q[DVW];
  assign prod_abs = prod_neg ? -prod_q : prod_q;
  assign prod_mag = prod_abs[DVW-1:0];

  stc_div #(.DVW(DVW), .DSW(NW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV),
    .dividend_i (prod_mag),
    .divisor_i  (den_q),
    .busy_o     (div_busy),
    .quot_o     (quot_mag)
  );

  assign quot_s = prod_neg ? -PW'(quot_mag) : PW'(quot_mag);

  // DDA length
  logic signed [PW-1:0] ddx, ddy;
  logic [PW-1:0] mx, my, mm, nsum;
  always_comb begin
    ddx  = bx_q - ax_q;
    ddy  = by_q - ay_q;
    mx   = ddx[PW-1] ? PW'(-ddx) : PW'(ddx);
    my   = ddy[PW-1] ? PW'(-ddy) : PW'(ddy);
    mm   = (mx > my) ? mx : my;
    nsum = (mm + PW'((1 << FRAC_BITS) - 1)) >> FRAC_BITS;
  end

  // edge endpoints
  logic [CW-1:0] ejx, ejy, ekx, eky;
  always_comb begin
    case (cmd_i.row[1:0])
      2'd0: begin ejx = oax_q; ejy = oay_q; ekx = obx_q; eky = oby_q; end
      2'd1: begin ejx = obx_q; ejy = oby_q; ekx = ocx_q; eky = ocy_q; end
      default: begin ejx = ocx_q; ejy = ocy_q; ekx = oax_q; eky = oay_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0; s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0; s5_q <= '0;
      oax_q <= '0; oay_q <= '0; obx_q <= '0; oby_q <= '0; ocx_q <= '0; ocy_q <= '0;
      colour_q <= '0;
      split_q <= '0; ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
      dx_q <= '0; dy_q <= '0; stx_q <= '0; sty_q <= '0;
      n_q <= '0; den_q <= '0; rem_q <= '0; prod_q <= '0;
      px_q <= '0; py_q <= '0; word_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          s0_q <= t0x; s1_q <= t0y; s2_q <= t1x; s3_q <= t1y; s4_q <= t2x; s5_q <= t2y;
          oax_q <= vert_a_x_i; oay_q <= vert_a_y_i;
          obx_q <= vert_b_x_i; oby_q <= vert_b_y_i;
          ocx_q <= vert_c_x_i; ocy_q <= vert_c_y_i;
          colour_q <= {red_i, green_i, blue_i};
        end
        OP_MUL: begin
          prod_q <= prod_w[DVW:0];
          den_q  <= den_d;
        end
        OP_WB: begin
          case (cmd_i.sel)
            SEL_SPLIT: split_q <= scl(s0_q) - quot_s;
            SEL_AX:    ax_q <= scl(bx0) + quot_s;
            SEL_AY: begin
              ay_q <= scl(by0) + quot_s;
              by_q <= scl(by0) + quot_s;
            end
            SEL_BX:    bx_q <= scl(bx0) + quot_s;
            SEL_SX:    stx_q <= quot_s;
            default:   sty_q <= quot_s;
          endcase
        end
        OP_EDGE: begin
          ax_q <= scl(ejx); ay_q <= scl(ejy);
          bx_q <= scl(ekx); by_q <= scl(eky);
        end
        OP_DDA: begin
          dx_q <= ddx;
          dy_q <= ddy;
          n_q  <= nsum[NW-1:0];
        end
        OP_RUN: rem_q <= n_q;
        OP_TICK: begin
          px_q   <= to_pix(ax_q, SCREEN_WIDTH);
          py_q   <= to_pix(ay_q, SCREEN_HEIGHT);
          word_q <= {ALPHA, colour_q};
          ax_q   <= ax_q + stx_q;
          ay_q   <= ay_q + sty_q;
          rem_q  <= rem_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic row_end;
  always_comb begin
    case (cmd_i.phase)
      PH_TOP:  row_end = cmd_i.row == ({1'b0, s1_q} - {1'b0, s3_q});
      PH_BOT:  row_end = cmd_i.row == ({1'b0, s3_q} - {1'b0, s5_q});
      PH_EDGE: row_end = cmd_i.row == RW'(2);
      default: row_end = 1'b1;
    endcase
  end

  assign sts_o.flat     = (s1_q == s5_q);
  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.rem_one  = (rem_q == NW'(1));
  assign sts_o.row_end  = row_end;
  assign sts_o.div_busy = div_busy;

  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign pixel_word_o = word_q;
endmodule

/* rtl/stc_ctrl.sv */
// Controller: request handshake, draw phase and row sequencing, span setup sequencer.
module stc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          opcode_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          last_pixel_o,
  output stc_pkg::cmd_t cmd_o,
  input  stc_pkg::sts_t sts_i
);
  import stc_pkg::*;

  typedef enum logic [3:0] {
    S_WAIT, S_LOADED, S_MUL, S_DIVGO, S_DIVW, S_SETUP, S_DDA, S_CHK, S_RUN, S_NEXT
  } state_e;

  state_e        state_q;
  phase_e        phase_q;
  logic [RW-1:0] row_q;
  sel_e          sel_q;
  logic          pend_q, out_valid_q, last_q;
  logic          acc;

  assign in_stall_o = !(state_q == S_WAIT && (!out_valid_q || !out_stall_i));
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.sel   = sel_q;
    cmd_o.phase = phase_q;
    cmd_o.row   = row_q;
    case (state_q)
      S_WAIT: begin
        if (acc && opcode_i == OPC_LOAD) cmd_o.op = OP_LOAD;
        else if (acc && phase_q != PH_IDLE) cmd_o.op = OP_TICK;
      end
      S_MUL:   cmd_o.op = OP_MUL;
      S_DIVGO: cmd_o.op = OP_DIV;
      S_DIVW:  if (!sts_i.div_busy) cmd_o.op = OP_WB;
      S_SETUP: if (phase_q == PH_EDGE) cmd_o.op = OP_EDGE;
      S_DDA:   cmd_o.op = OP_DDA;
      S_RUN:   cmd_o.op = OP_RUN;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_WAIT;
      phase_q     <= PH_IDLE;
      row_q       <= '0;
      sel_q       <= SEL_SPLIT;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_WAIT: begin
          if (acc) begin
            if (opcode_i == OPC_LOAD) begin
              state_q <= S_LOADED;
            end else if (phase_q != PH_IDLE) begin
              if (sts_i.rem_one) begin
                pend_q  <= 1'b1;
                state_q <= S_NEXT;
              end else begin
                out_valid_q <= 1'b1;
                last_q      <= 1'b0;
              end
            end
          end
        end
        S_LOADED: begin
          row_q <= '0;
          if (sts_i.flat) begin
            phase_q <= PH_EDGE;
            state_q <= S_SETUP;
          end else begin
            sel_q   <= SEL_SPLIT;
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_DIVGO;
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW: begin
          if (!sts_i.div_busy) begin
            case (sel_q)
              SEL_SPLIT: begin
                phase_q <= PH_TOP;
                state_q <= S_SETUP;
              end
              SEL_AX: begin
                sel_q   <= SEL_AY;
                state_q <= S_MUL;
              end
              SEL_AY: begin
                sel_q   <= SEL_BX;
                state_q <= S_MUL;
              end
              SEL_BX: state_q <= S_DDA;
              SEL_SX: begin
                sel_q   <= SEL_SY;
                state_q <= S_MUL;
              end
              default: state_q <= S_RUN;
            endcase
          end
        end
        S_SETUP: begin
          if (phase_q == PH_EDGE) begin
            state_q <= S_DDA;
          end else begin
            sel_q   <= SEL_AX;
            state_q <= S_MUL;
          end
        end
        S_DDA: state_q <= S_CHK;
        S_CHK: begin
          if (sts_i.n_zero) begin
            state_q <= S_NEXT;
          end else begin
            sel_q   <= SEL_SX;
            state_q <= S_MUL;
          end
        end
        S_RUN: begin
          state_q <= S_WAIT;
          if (pend_q) begin
            out_valid_q <= 1'b1;
            last_q      <= 1'b0;
            pend_q      <= 1'b0;
          end
        end
        S_NEXT: begin
          if (sts_i.row_end) begin
            row_q <= '0;
            case (phase_q)
              PH_TOP: begin
                phase_q <= PH_BOT;
                state_q <= S_SETUP;
              end
              PH_BOT: begin
                phase_q <= PH_EDGE;
                state_q <= S_SETUP;
              end
              default: begin
                phase_q <= PH_IDLE;
                state_q <= S_WAIT;
                if (pend_q) begin
                  out_valid_q <= 1'b1;
                  last_q      <= 1'b1;
                  pend_q      <= 1'b0;
                end
              end
            endcase
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= S_SETUP;
          end
        end
        default: state_q <= S_WAIT;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign last_pixel_o = last_q;
endmodule

/* tb/tb_scanline_triangle_filler_unit.sv */
// Testbench for the scanline triangle filler: directed table, then random triangles and ticks.
module tb_scanline_triangle_filler_unit;
  import stc_pkg::*;

  localparam longint ONE = longint'(1) << DEF_FRAC_BITS;
  localparam int WATCH_LIMIT = 1000000;
  localparam int N_DIR = 16;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [31:0]   word;
    logic          last;
  } pixel_t;

  typedef struct {
    logic              op;
    logic [5:0][CW-1:0] v;
    logic [7:0]        r, g, b;
    bit                typed;
    bit                none;
    pixel_t            px;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = OPC_TICK;
  logic [CW-1:0] vert_a_x_i = '0, vert_a_y_i = '0, vert_b_x_i = '0;
  logic [CW-1:0] vert_b_y_i = '0, vert_c_x_i = '0, vert_c_y_i = '0;
  logic [COLW-1:0] red_i = '0, green_i = '0, blue_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CW-1:0] pixel_x_o, pixel_y_o;
  logic [4*COLW-1:0] pixel_word_o;
  logic last_pixel_o;

  scanline_triangle_filler_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // triangle state mirror
  longint srt[6], orig[6], split_x, row, pos[2], stp[2], remain;
  logic [23:0] colour;
  phase_e phase = PH_IDLE;

  pixel_t pending_pixels[$];
  int mismatches = 0, failures = 0, idle_cycles = 0;
  bit calm = 0;
  int stall_burst = 0;

  function automatic longint mag(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic void open_span();
    longint ax = 0, ay = 0, bx = 0, by = 0, den, dx, dy, m, n;
    int j, k;
    if (phase == PH_TOP) begin
      den = srt[1] - srt[3] + 1;
      ax = srt[0] * ONE + (row * (split_x - srt[0] * ONE)) / den;
      ay = srt[1] * ONE + (row * (srt[3] - srt[1]) * ONE) / den;
      bx = srt[0] * ONE + (row * (srt[2] - srt[0]) * ONE) / den;
      by = ay;
    end else if (phase == PH_BOT) begin
      den = srt[3] - srt[5] + 1;
      ax = srt[4] * ONE + (row * (split_x - srt[4] * ONE)) / den;
      ay = srt[5] * ONE + (row * (srt[3] - srt[5]) * ONE) / den;
      bx = srt[4] * ONE + (row * (srt[2] - srt[4]) * ONE) / den;
      by = ay;
    end else if (phase == PH_EDGE) begin
      j = int'(row % 3);
      k = (j + 1) % 3;
      ax = orig[2*j] * ONE;
      ay = orig[2*j+1] * ONE;
      bx = orig[2*k] * ONE;
      by = orig[2*k+1] * ONE;
    end
    dx = bx - ax;
    dy = by - ay;
    m = mag(dx) > mag(dy) ? mag(dx) : mag(dy);
    n = (m + ONE - 1) / ONE;
    pos[0] = ax;
    pos[1] = ay;
    stp[0] = n > 0 ? dx / n : 0;
    stp[1] = n > 0 ? dy / n : 0;
    remain = phase == PH_IDLE ? 0 : n;
  endfunction

  function automatic void next_span();
    while (phase != PH_IDLE && remain == 0) begin
      row++;
      if (phase == PH_TOP && row > srt[1] - srt[3]) begin
        phase = PH_BOT;
        row = 0;
      end else if (phase == PH_BOT && row > srt[3] - srt[5]) begin
        phase = PH_EDGE;
        row = 0;
      end else if (phase == PH_EDGE && row > 2) begin
        phase = PH_IDLE;
        row = 0;
      end
      open_span();
    end
  endfunction

  function automatic void swap_vert(int a, int b);
    longint tx = srt[2*a], ty = srt[2*a+1];
    srt[2*a] = srt[2*b];
    srt[2*a+1] = srt[2*b+1];
    srt[2*b] = tx;
    srt[2*b+1] = ty;
  endfunction

  function automatic void load_triangle(logic [5:0][CW-1:0] v, logic [7:0] r, g, b);
    for (int i = 0; i < 6; i++) begin
      orig[i] = longint'(v[i]);
      srt[i] = orig[i];
    end
    colour = {r, g, b};
    if (srt[1] < srt[3]) swap_vert(0, 1);
    if (srt[1] < srt[5]) swap_vert(0, 2);
    if (srt[3] < srt[5]) swap_vert(1, 2);
    row = 0;
    if (srt[1] == srt[5]) begin
      split_x = srt[0] * ONE;
      phase = PH_EDGE;
    end else begin
      split_x = srt[0] * ONE - ((srt[1] - srt[3]) * (srt[0] - srt[4]) * ONE) / (srt[1] - srt[5]);
      phase = PH_TOP;
    end
    open_span();
    next_span();
  endfunction

  function automatic logic [CW-1:0] clamp_pixel(longint a, longint lim);
    longint p = a < 0 ? 0 : a / ONE;
    if (p > lim - 1) p = lim - 1;
    return p[CW-1:0];
  endfunction

  function automatic bit emit_pixel(output pixel_t px);
    if (phase == PH_IDLE) return 0;
    px.x = clamp_pixel(pos[0], DEF_SCREEN_W);
    px.y = clamp_pixel(pos[1], DEF_SCREEN_H);
    px.word = {ALPHA, colour};
    pos[0] += stp[0];
    pos[1] += stp[1];
    remain--;
    next_span();
    px.last = phase == PH_IDLE;
    return 1;
  endfunction

  // send one request; predicted pixel is queued on acceptance
  task automatic send(logic op, logic [5:0][CW-1:0] v, logic [7:0] r, g, b,
                      bit typed = 0, bit none = 0, pixel_t want = '{default: '0});
    pixel_t px;
    bit got;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    {vert_c_y_i, vert_c_x_i, vert_b_y_i, vert_b_x_i, vert_a_y_i, vert_a_x_i} <= v;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OPC_LOAD) load_triangle(v, r, g, b);
    else begin
      got = emit_pixel(px);
      if (typed) begin
        if (!none) pending_pixels = {pending_pixels, want};
      end else if (got) pending_pixels = {pending_pixels, px};
    end
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        failures++;
        if (mismatches++ < 10)
          $display("unexpected pixel: exp none got x=%0d y=%0d", pixel_x_o, pixel_y_o);
      end else begin
        e = pending_pixels.pop_front();
        if (e.x !== pixel_x_o || e.y !== pixel_y_o || e.word !== pixel_word_o ||
            e.last !== last_pixel_o) begin
          failures++;
          if (mismatches++ < 10)
            $display("pixel mismatch: exp x=%0d y=%0d w=%h l=%b got x=%0d y=%0d w=%h l=%b",
                     e.x, e.y, e.word, e.last, pixel_x_o, pixel_y_o, pixel_word_o,
                     last_pixel_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (calm || !rst_ni) out_stall_i <= 1'b0;
    else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_burst <= $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else out_stall_i <= 1'b0;
  end

  dir_row_t dir_rows [N_DIR];

  function automatic logic [5:0][CW-1:0] verts(int ax, ay, bx, by, cx, cy);
    return {CW'(cy), CW'(cx), CW'(by), CW'(bx), CW'(ay), CW'(ax)};
  endfunction

  initial begin
    logic [5:0][CW-1:0] v;
    int sent, base_x, base_y, span, ticks;
    dir_rows = '{
      '{OPC_TICK, '0, 0, 0, 0, 1, 1, '{0, 0, 0, 0}},
      '{OPC_LOAD, verts(0, 0, 1, 0, 0, 0), 8'hFF, 8'hFF, 8'hFF, 0, 0, '{0, 0, 0, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 1, 0, '{0, 0, 32'hFFFFFFFF, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 1, 0, '{1, 0, 32'hFFFFFFFF, 1}},
      '{OPC_TICK, '0, 0, 0, 0, 1, 1, '{0, 0, 0, 0}},
      '{OPC_LOAD, verts(511, 511, 511, 511, 511, 511), 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 1, 1, '{0, 0, 0, 0}},
      '{OPC_LOAD, verts(0, 0, 511, 511, 511, 0), 8'h12, 8'h34, 8'h56, 0, 0, '{0, 0, 0, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{OPC_LOAD, verts(0, 511, 511, 511, 255, 511), 8'hA5, 8'h5A, 8'hC3, 0, 0, '{0, 0, 0, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{OPC_LOAD, verts(3, 7, 9, 2, 1, 4), 8'h01, 8'h80, 8'h7F, 0, 0, '{0, 0, 0, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{OPC_LOAD, verts(5, 5, 5, 9, 8, 5), 8'hFE, 8'h00, 8'hFF, 0, 0, '{0, 0, 0, 0}},
      '{OPC_TICK, '0, 0, 0, 0, 0, 0, '{0, 0, 0, 0}}
    };
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send(dir_rows[i].op, dir_rows[i].v, dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
           dir_rows[i].typed, dir_rows[i].none, dir_rows[i].px);

    sent = N_DIR;
    while (sent < 400) begin
      if (sent > 340) calm = 1;
      span = $urandom_range(0, 9) == 0 ? 511 : $urandom_range(0, 3) == 0 ? 15 : 7;
      base_x = $urandom_range(0, 511 - span);
      base_y = $urandom_range(0, 511 - span);
      v = verts(base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
                base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
                base_x + $urandom_range(0, span), base_y + $urandom_range(0, span));
      send(OPC_LOAD, v, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)));
      sent++;
      ticks = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 60;
      while (ticks > 0 && phase != PH_IDLE) begin
        send(OPC_TICK, v, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
        sent++;
        ticks--;
      end
      if ($urandom_range(0, 7) == 0 && phase == PH_IDLE) begin
        send(OPC_TICK, v, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
        sent++;
      end
    end
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (failures == 0 && pending_pixels.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
